>>> hw/rtl/mbkd_pkg.sv
// shared types and constants for the multi-bank key debouncer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mbkd_pkg;

  localparam int BANKS         = 4;
  localparam int KEYS_PER_BANK = 16;

  // field widths fixed by the interface
  localparam int BANK_W   = 2;
  localparam int KEY_W    = 4;
  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 4;
  localparam int CNT_W    = 4;
  localparam int ENABLE_W = 64;
  localparam int SHIFT_W  = $clog2(ENABLE_W) + 1;

  // stream payload widths
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 8;
  localparam int M_USER_W = 2;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(4);
  localparam logic [ENABLE_W-1:0] ENABLE_RESET = '1;

  // decoupling queue between classifier and serializer
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [THR_W-1:0]    threshold;
    logic [ENABLE_W-1:0] enable;
  } cfg_t;

  // one scan's worth of events
  typedef struct packed {
    logic [BANK_W-1:0]        bank;
    logic [KEYS_PER_BANK-1:0] flip;   // keys whose state changed
    logic [KEYS_PER_BANK-1:0] press;  // new state of those keys, 1 = pressed
    logic                     offline;
  } evt_t;

endpackage

>>> hw/rtl/mbkd_front.sv
// scan classifier: holds debounced state, counters and offline flags
// and turns one accepted scan into an event mask; uses mbkd_pkg
`timescale 1ns / 1ps

module mbkd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  mbkd_pkg::cfg_t                 cfg,
  input  logic                           accept,
  input  logic [mbkd_pkg::BANK_W-1:0]    bank,
  input  logic [mbkd_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           read_ok,
  output logic                           push,
  output mbkd_pkg::evt_t                 push_data
);
  import mbkd_pkg::*;

  logic [KEYS_PER_BANK-1:0]            state_mem [BANKS];
  logic [KEYS_PER_BANK-1:0][CNT_W-1:0] cnt_mem   [BANKS];
  logic [BANKS-1:0]                    offline;

  logic                            bank_ok;
  logic                            live;
  logic [ENABLE_W-1:0]             en_shift;
  logic [KEYS_PER_BANK-1:0]        en_row;
  logic [KEYS_PER_BANK-1:0]        st_row;
  logic [KEYS_PER_BANK-1:0]        st_new;
  logic [KEYS_PER_BANK-1:0]        flip;
  logic [KEYS_PER_BANK-1:0][CNT_W-1:0] cnt_row;
  logic [KEYS_PER_BANK-1:0][CNT_W-1:0] cnt_new;

  assign bank_ok  = ({1'b0, bank} < (BANK_W+1)'(BANKS));
  assign live     = accept && bank_ok && !offline[bank];
  assign en_shift = cfg.enable >> (SHIFT_W'(bank) << KEY_W);
  assign en_row   = en_shift[KEYS_PER_BANK-1:0];
  assign st_row   = state_mem[bank];
  assign cnt_row  = cnt_mem[bank];

  for (genvar k = 0; k < KEYS_PER_BANK; k++) begin : g_key
    logic           now;
    logic           differs;
    logic [CNT_W:0] inc;
    assign now     = ~sample[k];
    assign differs = (now != st_row[k]);
    assign inc     = (CNT_W+1)'(cnt_row[k]) + (CNT_W+1)'(1);
    assign flip[k] = en_row[k] && differs && (inc >= (CNT_W+1)'(cfg.threshold));
    assign cnt_new[k] = !en_row[k]           ? cnt_row[k] :
                        (!differs || flip[k]) ? '0 : inc[CNT_W-1:0];
  end

  assign st_new = st_row ^ flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANKS; b++) begin
        state_mem[b] <= '0;
        cnt_mem[b]   <= '0;
      end
      offline <= '0;
    end else if (live) begin
      if (!read_ok) begin
        offline[bank] <= 1'b1;
      end else begin
        state_mem[bank] <= st_new;
        cnt_mem[bank]   <= cnt_new;
      end
    end
  end

  // only scans that flip at least one key go to the serializer
  assign push              = live && read_ok && (|flip);
  assign push_data.bank    = bank;
  assign push_data.flip    = flip;
  assign push_data.press   = st_new & flip;
  assign push_data.offline = |offline;

endmodule

>>> hw/rtl/mbkd_queue.sv
// small fifo of event masks between classifier and serializer
// uses mbkd_pkg for the entry type and depth
`timescale 1ns / 1ps

module mbkd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbkd_pkg::evt_t push_data,
  output logic           full,
  output logic           q_valid,
  output mbkd_pkg::evt_t q_data,
  input  logic           pop
);
  import mbkd_pkg::*;

  evt_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop)) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + (QPTR_W+1)'(1)))
    else $error("queue count did not advance");

  a_nonempty_mask: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_data.flip != '0)) else $error("empty event mask queued");

endmodule

>>> hw/rtl/mbkd_back.sv
// event serializer: emits one word per flipped key, lowest key first,
// through a registered output stage; uses mbkd_pkg
`timescale 1ns / 1ps

module mbkd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  mbkd_pkg::evt_t                 q_data,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mbkd_pkg::M_DATA_W-1:0]  m_tdata,   // [1:0] event_bank, [5:2] event_key
  output logic [mbkd_pkg::M_USER_W-1:0]  m_tuser,   // [0] pressed, [1] any_offline
  output logic                           m_tlast
);
  import mbkd_pkg::*;

  logic [BANK_W-1:0]        pend_bank;
  logic [KEYS_PER_BANK-1:0] pend_flip;
  logic [KEYS_PER_BANK-1:0] pend_press;
  logic                     pend_off;

  logic [KEY_W-1:0]         sel;
  logic [KEYS_PER_BANK-1:0] rest;
  logic                     out_free;
  logic                     advance;

  always_comb begin
    sel = '0;
    for (int k = KEYS_PER_BANK - 1; k >= 0; k--) begin
      if (pend_flip[k]) sel = KEY_W'(k);
    end
  end

  assign rest     = pend_flip & (pend_flip - KEYS_PER_BANK'(1));
  assign out_free = !m_tvalid || m_tready;
  assign advance  = out_free && (pend_flip != '0);
  assign pop      = q_valid && ((pend_flip == '0) || (advance && (rest == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_flip <= '0;
    end else if (pop) begin
      pend_flip <= q_data.flip;
    end else if (advance) begin
      pend_flip <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend_bank  <= q_data.bank;
      pend_press <= q_data.press;
      pend_off   <= q_data.offline;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {(M_DATA_W - KEY_W - BANK_W)'(0), sel, pend_bank};
      m_tuser <= {pend_off, pend_press[sel]};
      m_tlast <= (rest == '0);
    end
  end

endmodule

>>> hw/rtl/multi_bank_key_debouncer.sv
// top level of the multi-bank key debouncer: config registers, handshake
// and the classifier / queue / serializer chain; uses mbkd_pkg and
// mbkd_front, mbkd_queue, mbkd_back
`timescale 1ns / 1ps

// usage
//   slave stream: one word per scan of one bank. tdata carries the bank
//   index and the 16 active-low key levels, tuser says the bus read worked.
//   a failed read takes that bank offline until reset.
//   master stream: one word per key whose debounced state flipped, in
//   ascending key order; tlast marks the final event of a scan, tuser
//   carries press/release and the any-bank-offline flag.
//   config: cfg_index 0 = debounce threshold (4 bits), 1 = 64-bit key
//   enable mask (bit bank*16+key). write only while the block is idle.
// timing
//   a scan is classified in the cycle it is accepted; its events then pass
//   through the event queue, the serializer's pending mask and the output
//   register to the master side. scans are taken every cycle while the
//   4-entry event queue has room; the serializer gives one event per cycle
//   while the receiver is ready. scans with no flips leave nothing in the queue.
// reset: rst clears all key states, counters and offline flags at once,
//   sets threshold 4 and all keys enabled; no clearing pass is needed
// stalls
//   a stalled receiver holds the output register; the queue absorbs up
//   to 4 scans with events before s_tready drops.

module multi_bank_key_debouncer (
  input  logic                             clk,
  input  logic                             rst,
  // scan input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mbkd_pkg::S_DATA_W-1:0]    s_tdata,   // [1:0] bank, [17:2] sample
  input  logic                             s_tuser,   // [0] read_ok
  // event output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mbkd_pkg::M_DATA_W-1:0]    m_tdata,   // [1:0] event_bank, [5:2] event_key
  output logic [mbkd_pkg::M_USER_W-1:0]    m_tuser,   // [0] pressed, [1] any_offline
  output logic                             m_tlast,   // last_event
  // config writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mbkd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbkd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mbkd_pkg::*;

  cfg_t cfg;
  evt_t push_data;
  evt_t q_data;
  logic push;
  logic pop;
  logic full;
  logic q_valid;
  logic accept;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THR_RESET;
      cfg.enable    <= ENABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD: cfg.threshold <= cfg_data[THR_W-1:0];
        REG_ENABLE:    cfg.enable    <= cfg_data[ENABLE_W-1:0];
        default:       ;
      endcase
    end
  end

  // input side stalls only on a full event queue
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  mbkd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .bank      (s_tdata[BANK_W-1:0]),
    .sample    (s_tdata[BANK_W +: SAMPLE_W]),
    .read_ok   (s_tuser),
    .push      (push),
    .push_data (push_data)
  );

  mbkd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  mbkd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> verif/tb_multi_bank_key_debouncer.sv
// self-checking testbench for multi_bank_key_debouncer: directed and random bank scans
// checked against a cycle-free debounce predictor; depends on mbkd_pkg and the rtl top
`timescale 1ns / 1ps

module tb_multi_bank_key_debouncer;
  import mbkd_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  // leave margin after the last expected event before config writes
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX    = 10;

  // one expected key event, fields as they leave the master stream
  typedef struct {
    logic [BANK_W-1:0] bank;
    logic [KEY_W-1:0]  key;
    logic              pressed;
    logic              last;
    logic              offline;
  } key_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata  = '0;  // [1:0] bank, [17:2] sample
  logic                  s_tuser  = 1'b0; // [0] read_ok
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;        // [1:0] event_bank, [5:2] event_key
  logic [M_USER_W-1:0]   m_tuser;        // [0] pressed, [1] any_offline
  logic                  m_tlast;        // last_event
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  multi_bank_key_debouncer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block's registers and per-key state
  logic [THR_W-1:0]         exp_threshold = THR_RESET;
  logic [ENABLE_W-1:0]      exp_enable    = ENABLE_RESET;
  logic [SAMPLE_W-1:0]      exp_level [BANKS];           // debounced, 1 = pressed
  logic [CNT_W-1:0]         exp_streak [BANKS*KEYS_PER_BANK];
  logic [BANKS-1:0]         exp_bank_down = '0;

  key_event_t pending_events[$];
  int         mismatches  = 0;
  int         cycle_count = 0;

  // idling percentages for the current phase
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;

  // per-bank pattern that random traffic holds long enough to debounce
  logic [SAMPLE_W-1:0] held_pattern [BANKS];

  initial begin
    for (int b = 0; b < BANKS; b++) begin
      exp_level[b]    = '0;
      held_pattern[b] = '1;
    end
    for (int i = 0; i < BANKS*KEYS_PER_BANK; i++) exp_streak[i] = '0;
  end

  // work out the events one accepted scan causes and queue them in key order
  task automatic debounce_scan(input logic [BANK_W-1:0] bank,
                               input logic [SAMPLE_W-1:0] sample,
                               input logic read_ok);
    key_event_t found [KEYS_PER_BANK];
    int         n_found;
    int         slot;
    logic       now_down;
    logic [4:0] streak;
    logic       any_down;
    n_found = 0;
    if (!exp_bank_down[bank]) begin
      if (!read_ok) begin
        // bank drops out for good, no events from this scan
        exp_bank_down[bank] = 1'b1;
      end else begin
        any_down = |exp_bank_down;
        for (int k = 0; k < KEYS_PER_BANK; k++) begin
          slot = bank * KEYS_PER_BANK + k;
          if (exp_enable[bank*16 + k]) begin
            now_down = ~sample[k];
            if (now_down == exp_level[bank][k]) begin
              exp_streak[slot] = '0;
            end else begin
              streak = {1'b0, exp_streak[slot]} + 5'd1;
              // a threshold of zero flips on the first differing sample
              if (streak >= {1'b0, exp_threshold}) begin
                exp_level[bank][k]       = now_down;
                exp_streak[slot]         = '0;
                found[n_found].bank      = bank;
                found[n_found].key       = KEY_W'(k);
                found[n_found].pressed   = now_down;
                found[n_found].last      = 1'b0;
                found[n_found].offline   = any_down;
                n_found++;
              end else begin
                exp_streak[slot] = streak[CNT_W-1:0];
              end
            end
          end
        end
      end
    end
    for (int i = 0; i < n_found; i++) begin
      if (i == n_found - 1) found[i].last = 1'b1;
      pending_events.push_back(found[i]);
    end
  endtask

  // monitor: config writes and scans update the predictor, events are checked
  always @(posedge clk) begin : event_check
    key_event_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_THRESHOLD)
          exp_threshold = cfg_data[THR_W-1:0];
        else if (cfg_index == REG_ENABLE)
          exp_enable = cfg_data;
      end
      if (s_tvalid && s_tready)
        debounce_scan(s_tdata[1:0], s_tdata[17:2], s_tuser);
      if (m_tvalid && m_tready) begin
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected event bank %0d key %0d pressed %0b last %0b offline %0b",
                     $realtime, m_tdata[1:0], m_tdata[5:2], m_tuser[0], m_tlast, m_tuser[1]);
        end else begin
          want = pending_events.pop_front();
          if (m_tdata[1:0] !== want.bank || m_tdata[5:2] !== want.key ||
              m_tuser[0] !== want.pressed || m_tlast !== want.last ||
              m_tuser[1] !== want.offline) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: expected b%0d k%0d p%0b l%0b o%0b, got b%0d k%0d p%0b l%0b o%0b",
                       $realtime, want.bank, want.key, want.pressed, want.last, want.offline,
                       m_tdata[1:0], m_tdata[5:2], m_tuser[0], m_tlast, m_tuser[1]);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver side: random stalls at the phase's rate
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= sink_stall_pct);

  // one scan word; returns at the falling edge after it was taken, valid still high
  task automatic send_scan(input logic [BANK_W-1:0] bank,
                           input logic [SAMPLE_W-1:0] sample,
                           input logic read_ok);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = S_DATA_W'({sample, bank});
    s_tuser  = read_ok;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending, wait for every expected event, then let the pipe settle
  task automatic drain;
    s_tvalid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // mostly held patterns with sparse bounce, now and then a new pattern or pure noise
  task automatic random_scans(input int count, input logic [BANKS-1:0] allowed);
    logic [BANK_W-1:0]   bank;
    logic [SAMPLE_W-1:0] bounce;
    int                  roll;
    for (int i = 0; i < count; i++) begin
      do bank = BANK_W'($urandom_range(BANKS-1)); while (!allowed[bank]);
      roll = $urandom_range(99);
      if (roll < 12) held_pattern[bank] = SAMPLE_W'($urandom);
      bounce = SAMPLE_W'($urandom & $urandom & $urandom & $urandom);
      if (roll < 85)
        send_scan(bank, held_pattern[bank] ^ bounce, 1'b1);
      else
        send_scan(bank, SAMPLE_W'($urandom), 1'b1);
    end
  endtask

  // reset threshold of 4: presses at the edge keys, full-bank press,
  // and an agreeing sample that clears a partial count
  task automatic test_press_release;
    repeat (4) send_scan(2'd0, 16'h7FFE, 1'b1);
    repeat (3) send_scan(2'd3, 16'h0000, 1'b1);
    send_scan(2'd3, 16'hFFFF, 1'b1);
    repeat (4) send_scan(2'd3, 16'h0000, 1'b1);
    drain();
  endtask

  // threshold zero acts as one; threshold 15 needs fifteen scans in a row
  task automatic test_threshold_extremes;
    cfg_write(REG_THRESHOLD, CFG_DATA_W'(0));
    send_scan(2'd1, 16'hA5A5, 1'b1);
    send_scan(2'd1, 16'hFFFF, 1'b1);
    drain();
    cfg_write(REG_THRESHOLD, CFG_DATA_W'(15));
    repeat (15) send_scan(2'd2, 16'h00FF, 1'b1);
    drain();
  endtask

  // disabled keys neither flip nor count
  task automatic test_enable_mask;
    cfg_write(REG_THRESHOLD, CFG_DATA_W'(1));
    cfg_write(REG_ENABLE, '0);
    send_scan(2'd1, 16'h0000, 1'b1);
    send_scan(2'd2, 16'hFFFF, 1'b1);
    drain();
    // bank 2 only
    cfg_write(REG_ENABLE, 64'h0000_FFFF_0000_0000);
    send_scan(2'd2, 16'hFFFF, 1'b1);
    send_scan(2'd1, 16'h0000, 1'b1);
    drain();
    // every other key
    cfg_write(REG_ENABLE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_scan(2'd1, 16'h0000, 1'b1);
    send_scan(2'd0, 16'hFFFF, 1'b1);
    drain();
  endtask

  // four idling phases, each with its own threshold and a sparse-holed mask
  task automatic test_random_traffic;
    int                  thr_pick [4];
    int                  src_pick [4];
    int                  sink_pick [4];
    logic [ENABLE_W-1:0] holes;
    thr_pick  = '{1, $urandom_range(2, 5), $urandom_range(1, 8), 3};
    src_pick  = '{0, 73, 0, 20};
    sink_pick = '{0, 0, 73, 20};
    for (int p = 0; p < 4; p++) begin
      holes = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      cfg_write(REG_THRESHOLD, CFG_DATA_W'(thr_pick[p]));
      cfg_write(REG_ENABLE, ~holes);
      set_idling(src_pick[p], sink_pick[p]);
      random_scans(25, 4'b1111);
      drain();
    end
  endtask

  // failed reads take banks offline; their scans are dropped and others flag it
  task automatic test_offline_banks;
    set_idling(20, 20);
    cfg_write(REG_THRESHOLD, CFG_DATA_W'(2));
    cfg_write(REG_ENABLE, '1);
    send_scan(2'd0, SAMPLE_W'($urandom), 1'b0);
    send_scan(2'd0, 16'h0000, 1'b1);
    send_scan(2'd0, 16'h0000, 1'b1);
    send_scan(2'd0, SAMPLE_W'($urandom), 1'b0);
    random_scans(15, 4'b1110);
    send_scan(2'd2, SAMPLE_W'($urandom), 1'b0);
    send_scan(2'd2, 16'hFFFF, 1'b1);
    random_scans(8, 4'b1010);
    drain();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_press_release();
    test_threshold_extremes();
    test_enable_mask();
    test_random_traffic();
    test_offline_banks();
    if (mismatches == 0 && pending_events.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mbkd_pkg.sv
hw/rtl/mbkd_front.sv
hw/rtl/mbkd_queue.sv
hw/rtl/mbkd_back.sv
hw/rtl/multi_bank_key_debouncer.sv
verif/tb_multi_bank_key_debouncer.sv
